// ===== rtl/core/statistical_mode_finder_core_defines.svh =====
// Assertion macros used by the mode finder top level.
`ifndef STATISTICAL_MODE_FINDER_CORE_DEFINES_SVH
`define STATISTICAL_MODE_FINDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SMF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define SMF_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SMF_ASSERT(lbl, clk, rst, prop, msg)
`define SMF_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/core/smf_pkg.sv =====
// Types and constants of the statistical mode finder.
`default_nettype none

package smf_pkg;

  // Depth of the queue between front and back; a power of two.
  localparam int SMF_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] sample_value;
    logic        last_item;
  } smf_item_t;

  typedef struct packed {
    logic        mode_found;
    logic [15:0] mode_value;
    logic        overflow;
  } smf_result_t;

  // One classified item on its way from front to back.
  typedef struct packed {
    smf_item_t item;
    logic      keep;
  } smf_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/smf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/smf_front.sv =====
// Front end: accepts items and marks each one as stored or dropped.
`default_nettype none

module smf_front
  import smf_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire smf_item_t  item,
  input  wire logic       full,
  output logic            busy,
  output logic            push,
  output smf_entry_t      entry
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] count;

  // Stall the source while the queue has no room.
  assign busy = full;
  assign push = start && !busy;

  // Keep the item while the set still has room in the store.
  always_comb begin
    entry.item = item;
    entry.keep = (count != CW'(MAX_ITEMS));
  end

  // Track how many items of the current set were kept for the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (item.last_item) begin
        count <= '0;
      end else if (entry.keep) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smf_queue.sv =====
// Short FIFO that decouples the front end from the evaluation back end.
`default_nettype none

module smf_queue
  import smf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire smf_entry_t  push_data,
  input  wire logic        pop,
  output smf_entry_t       head,
  output logic             full,
  output logic             empty
);

  localparam int PW  = (SMF_QUEUE_DEPTH > 1) ? $clog2(SMF_QUEUE_DEPTH) : 1;
  localparam int CNW = $clog2(SMF_QUEUE_DEPTH + 1);

  smf_entry_t     slots [SMF_QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = (count == CNW'(SMF_QUEUE_DEPTH));
  assign empty = (count == '0);

  // Advance pointers and occupancy on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

  // Hold payload in the slot under the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smf_back.sv =====
// Back end: stores values and runs the frequency-count mode search.
`default_nettype none

module smf_back
  import smf_pkg::*;
#(
  parameter int MAX_ITEMS  = 256,
  parameter int VALUE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire smf_entry_t  entry,
  input  wire logic        empty,
  output logic             pop,
  output logic             done,
  output smf_result_t      result
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_I,
    S_LATCH_I,
    S_SCAN,
    S_TAIL
  } state_t;

  state_t                state;
  logic [CW-1:0]         fill;
  logic                  overflow_seen;
  logic [CW-1:0]         idx_i;
  logic [CW-1:0]         idx_j;
  logic [CW-1:0]         hits;
  logic [CW-1:0]         best_count;
  logic [VALUE_BITS-1:0] best_value;
  logic [VALUE_BITS-1:0] probe;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;
  logic [31:0]           sample_ext;
  logic                  match;
  logic [CW-1:0]         total;
  logic                  take_best;
  logic [CW-1:0]         final_count;
  logic [VALUE_BITS-1:0] final_value;
  logic [31:0]           final_ext;
  logic                  last_j;
  logic                  last_i;

  // Drain the queue only between evaluations.
  assign pop = (state == S_IDLE) && !empty;

  // Store kept values at the fill position; mask to the value width.
  always_comb begin
    sample_ext = {16'b0, entry.item.sample_value};
    we         = pop && entry.keep;
    waddr      = fill[AW-1:0];
    wdata      = sample_ext[VALUE_BITS-1:0];
    raddr      = (state == S_LOAD_I) ? idx_i[AW-1:0] : idx_j[AW-1:0];
  end

  smf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Compare the element under test with the returning read data.
  always_comb begin
    match       = (rdata == probe);
    total       = hits + CW'(match);
    take_best   = (idx_i == '0) || (total > best_count);
    final_count = take_best ? total : best_count;
    final_value = take_best ? probe : best_value;
    final_ext   = 32'(final_value);
    last_j      = (idx_j == fill - CW'(1));
    last_i      = (idx_i == fill - CW'(1));
  end

  // Sequence loading, the outer element loop and the inner counting scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            fill          <= fill + CW'(entry.keep);
            overflow_seen <= overflow_seen | !entry.keep;
            if (entry.item.last_item) begin
              idx_i <= '0;
              state <= S_LOAD_I;
            end
          end
        end
        S_LOAD_I: begin
          state <= S_LATCH_I;
        end
        S_LATCH_I: begin
          probe <= rdata;
          idx_j <= '0;
          hits  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // Read data is registered, so it trails the scan address by one entry.
          if ((idx_j != '0) && match) begin
            hits <= hits + CW'(1);
          end
          idx_j <= idx_j + CW'(1);
          if (last_j) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          best_count <= final_count;
          best_value <= final_value;
          if (last_i) begin
            done              <= 1'b1;
            result.mode_found <= (final_count > CW'(1));
            result.mode_value <= (final_count > CW'(1)) ? final_ext[15:0] : 16'b0;
            result.overflow   <= overflow_seen;
            fill              <= '0;
            overflow_seen     <= 1'b0;
            state             <= S_IDLE;
          end else begin
            idx_i <= idx_i + CW'(1);
            state <= S_LOAD_I;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/statistical_mode_finder_core.sv =====
// Top level of the statistical mode finder: front end, queue and back end.
// Kept values pass the queue into the store at one per cycle while the back end is idle.
// After the last item, the back end searches the n stored values via the single read port:
// per element it latches it (LOAD_I, LATCH_I), scans the store (SCAN), updates the best (TAIL).
// Input stalls (busy high) once the two-entry queue fills during that search.
// The result is shown for one cycle under done; the receiver takes it unconditionally.
// Synchronous reset clears counters, queue and control; store contents are left as they are.
`default_nettype none

`include "statistical_mode_finder_core_defines.svh"

module statistical_mode_finder_core
  import smf_pkg::*;
#(
  parameter int MAX_ITEMS  = 256,
  parameter int VALUE_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire smf_item_t  item,
  output logic            busy,
  output logic            done,
  output smf_result_t     result
);

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  smf_entry_t push_entry;
  smf_entry_t head_entry;

  smf_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .entry (push_entry)
  );

  smf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head_entry),
    .full      (full),
    .empty     (empty)
  );

  smf_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (head_entry),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  // A result is a single-cycle strobe; consecutive results need a full search in between.
  `SMF_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done held for more than one cycle")
  // The back end never drains an empty queue.
  `SMF_NEVER(a_pop_empty, clk, rst, pop && empty, "queue popped while empty")
  // No mode means a zero value field.
  `SMF_NEVER(a_no_mode_zero, clk, rst, done && !result.mode_found && |result.mode_value, "stray value")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the statistical mode finder core.
`timescale 1ns / 1ps

module tb;
  import smf_pkg::*;

  localparam int MAX_ITEMS = 256;
  localparam int VALUE_BITS = 16;
  localparam logic [15:0] VALUE_MASK = 16'((33'd1 << VALUE_BITS) - 1);
  localparam int ITEMS_PER_PHASE = 120;
  // A full store is searched with no transfer; the limit allows several such searches.
  localparam int QUIET_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PLAN_ROWS = 20;

  // One row of the directed plan: a value sent reps times, last_item on the final copy if closes.
  typedef struct {
    logic [15:0] sample;
    bit          closes;
    int          reps;
    bit          typed;
    smf_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  smf_item_t   item;
  logic        busy;
  logic        done;
  smf_result_t result;

  // Mode predictor state
  logic [15:0] held_values [MAX_ITEMS];
  int          held_count = 0;
  bit          dropped_any = 1'b0;

  smf_result_t pending_modes [$];
  smf_result_t oldest_mode;
  plan_row_t   plan [PLAN_ROWS];

  int idle_pct = 0;
  int error_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int largest_set = 0;
  int quiet_cycles = 0;

  statistical_mode_finder_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Keep a sample or flag a drop if full; a closing sample finds the mode and clears the set.
  task automatic take_sample(input smf_item_t it, output bit closes, output smf_result_t mode);
    int hits;
    int best_hits;
    int best_at;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = it.sample_value & VALUE_MASK;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    closes = it.last_item;
    mode = '0;
    if (closes) begin
      best_hits = 0;
      best_at = 0;
      for (int i = 0; i < held_count; i++) begin
        hits = 0;
        for (int j = 0; j < held_count; j++) begin
          if (held_values[j] == held_values[i]) hits++;
        end
        // keep the earliest element with a strictly higher count
        if (i == 0 || hits > best_hits) begin
          best_hits = hits;
          best_at = i;
        end
      end
      mode.mode_found = (best_hits > 1);
      mode.mode_value = (best_hits > 1) ? held_values[best_at] : 16'h0000;
      mode.overflow = dropped_any;
      held_count = 0;
      dropped_any = 1'b0;
    end
  endtask

  // Idle at random, then hold start until the transfer; called at a rising edge.
  task automatic send_sample(input smf_item_t it, input bit typed, input smf_result_t want);
    bit          took;
    bit          closes;
    smf_result_t mode;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end
    take_sample(it, closes, mode);
    if (closes) pending_modes.push_back(typed ? want : mode);
    items_sent++;
  endtask

  // Hold off the sender until every pending mode has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_modes.size() != 0);
  endtask

  // Check each result against the oldest pending mode
  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_modes.size() == 0) begin
        report_mismatch($sformatf("result %h with no mode pending", result));
      end else begin
        oldest_mode = pending_modes.pop_front();
        results_checked++;
        if (result.mode_found !== oldest_mode.mode_found)
          report_mismatch($sformatf("mode_found %b, want %b",
                                    result.mode_found, oldest_mode.mode_found));
        if (result.mode_value !== oldest_mode.mode_value)
          report_mismatch($sformatf("mode_value %h, want %h",
                                    result.mode_value, oldest_mode.mode_value));
        if (result.overflow !== oldest_mode.overflow)
          report_mismatch($sformatf("overflow %b, want %b",
                                    result.overflow, oldest_mode.overflow));
      end
    end
  end

  // Watchdog: count cycles without any transfer or result
  always @(negedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles, %0d modes pending",
                 quiet_cycles, pending_modes.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    smf_item_t   it;
    logic [15:0] pool [4];
    int          set_len;
    int          phase_base;
    int          phase_idle [3];

    phase_idle = '{0, 68, 24};
    plan = '{
      // single value: no mode; then a repeated value: mode found
      '{16'h0000, 1'b1, 1,   1'b1, {1'b0, 16'h0000, 1'b0}},
      '{16'hFFFF, 1'b0, 1,   1'b0, '0},
      '{16'hFFFF, 1'b1, 1,   1'b1, {1'b1, 16'hFFFF, 1'b0}},
      // all values distinct: no mode
      '{16'h0001, 1'b0, 1,   1'b0, '0},
      '{16'h0002, 1'b0, 1,   1'b0, '0},
      '{16'h8000, 1'b1, 1,   1'b1, {1'b0, 16'h0000, 1'b0}},
      // tie between two values: earliest wins
      '{16'h0005, 1'b0, 1,   1'b0, '0},
      '{16'h0007, 1'b0, 2,   1'b0, '0},
      '{16'h0005, 1'b1, 1,   1'b0, '0},
      // later value with the higher count; then the first value with the higher count
      '{16'h0003, 1'b0, 1,   1'b0, '0},
      '{16'h0009, 1'b0, 1,   1'b0, '0},
      '{16'h0009, 1'b1, 1,   1'b0, '0},
      '{16'hA5A5, 1'b0, 1,   1'b0, '0},
      '{16'h5A5A, 1'b0, 1,   1'b0, '0},
      '{16'hA5A5, 1'b1, 1,   1'b0, '0},
      // store filled exactly, no overflow
      '{16'h0000, 1'b0, 255, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1,   1'b1, {1'b1, 16'h0000, 1'b0}},
      // store overrun: extra values and the closing one dropped
      '{16'h1234, 1'b0, 256, 1'b0, '0},
      '{16'h5555, 1'b1, 3,   1'b1, {1'b1, 16'h1234, 1'b1}},
      // overflow flag cleared for the next set
      '{16'h0042, 1'b1, 1,   1'b1, {1'b0, 16'h0000, 1'b0}}
    };

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        it.sample_value = plan[r].sample;
        it.last_item = plan[r].closes && (k == plan[r].reps - 1);
        send_sample(it, plan[r].typed && it.last_item, plan[r].want);
      end
      if (plan[r].closes) sets_sent++;
    end
    drain_results();

    // Random sets, mostly short, values mostly drawn from a small pool to force repeats
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      phase_base = items_sent;
      while (items_sent - phase_base < ITEMS_PER_PHASE) begin
        set_len = ($urandom_range(19) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        for (int k = 0; k < 4; k++) pool[k] = 16'($urandom);
        for (int n = 0; n < set_len; n++) begin
          it.sample_value = ($urandom_range(9) < 6) ? pool[$urandom_range(3)] : 16'($urandom);
          it.last_item = (n == set_len - 1);
          send_sample(it, 1'b0, '0);
        end
        sets_sent++;
        if (set_len > largest_set) largest_set = set_len;
        if ($urandom_range(9) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d values in %0d sets, %0d modes checked, %0d mismatches",
             items_sent, sets_sent, results_checked, error_count);
    $display("summary: covered full store, overrun, ties and random sets up to %0d values",
             largest_set);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
